// ===== sv/lbtc_pkg.sv =====
// Package for the LRU block translation cache.
// Holds sizes, memory entry types, command structs and sequencer codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbtc_pkg;

    localparam int BLOCK_BITS = 16;
    localparam int NUM_BLOCKS = 4096;
    localparam int MAX_SLOTS  = 1024;

    localparam int ADDR_W   = 28;
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int BLK_W    = $clog2(NUM_BLOCKS);
    localparam int CNT_W    = 11;
    localparam int CLR_W    = $clog2(NUM_BLOCKS);
    localparam int MAPPED_W = 26;

    localparam logic [CNT_W-1:0] MIN_ACTIVE   = CNT_W'(2);
    localparam logic [CNT_W-1:0] MAX_ACTIVE   = CNT_W'(MAX_SLOTS);
    localparam logic [CLR_W-1:0] CLR_LAST     = CLR_W'(NUM_BLOCKS - 1);
    localparam logic [CLR_W-1:0] CLR_LIST_END = CLR_W'(MAX_SLOTS);

    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic KIND_READ        = 1'b0;
    localparam logic KIND_TOUCH       = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } b2s_ent_t;

    typedef struct packed {
        logic             full;
        logic [BLK_W-1:0] blk;
    } own_ent_t;

    typedef struct packed {
        logic              b2s_we;
        logic [BLK_W-1:0]  b2s_waddr;
        b2s_ent_t          b2s_wdata;
        logic [BLK_W-1:0]  b2s_raddr;
        logic              own_we;
        logic [SLOT_W-1:0] own_waddr;
        own_ent_t          own_wdata;
        logic [SLOT_W-1:0] own_raddr;
    } map_cmd_t;

    typedef struct packed {
        b2s_ent_t b2s_rd;
        own_ent_t own_rd;
    } map_rsp_t;

    typedef struct packed {
        logic              nxt_we;
        logic [SLOT_W-1:0] nxt_waddr;
        logic [SLOT_W-1:0] nxt_wdata;
        logic [SLOT_W-1:0] nxt_raddr;
        logic              prv_we;
        logic [SLOT_W-1:0] prv_waddr;
        logic [SLOT_W-1:0] prv_wdata;
        logic [SLOT_W-1:0] prv_raddr;
    } lru_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] nxt_rd;
        logic [SLOT_W-1:0] prv_rd;
    } lru_rsp_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_LOOK  = 7'b0000100,
        ST_EVICT = 7'b0001000,
        ST_LINK  = 7'b0010000,
        ST_LINK2 = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/lbtc_map.sv =====
// Block map memories: block-to-slot table and slot owner table.
// One write and one registered read per table each cycle. Uses lbtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbtc_map
    import lbtc_pkg::*;
(
    input  wire logic     clk,
    input  wire map_cmd_t cmd,
    output map_rsp_t      rsp
);

    b2s_ent_t b2s_mem [0:NUM_BLOCKS-1];
    own_ent_t own_mem [0:MAX_SLOTS-1];
    map_rsp_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.b2s_we)
        begin
            b2s_mem[cmd.b2s_waddr] <= cmd.b2s_wdata;
        end
        if (cmd.own_we)
        begin
            own_mem[cmd.own_waddr] <= cmd.own_wdata;
        end
        rsp_reg.b2s_rd <= b2s_mem[cmd.b2s_raddr];
        rsp_reg.own_rd <= own_mem[cmd.own_raddr];
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/lbtc_lru.sv =====
// Recency list link memories: next and previous slot of every slot.
// One write and one registered read per table each cycle. Uses lbtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbtc_lru
    import lbtc_pkg::*;
(
    input  wire logic     clk,
    input  wire lru_cmd_t cmd,
    output lru_rsp_t      rsp
);

    logic [SLOT_W-1:0] nxt_mem [0:MAX_SLOTS-1];
    logic [SLOT_W-1:0] prv_mem [0:MAX_SLOTS-1];
    lru_rsp_t          rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.nxt_we)
        begin
            nxt_mem[cmd.nxt_waddr] <= cmd.nxt_wdata;
        end
        if (cmd.prv_we)
        begin
            prv_mem[cmd.prv_waddr] <= cmd.prv_wdata;
        end
        rsp_reg.nxt_rd <= nxt_mem[cmd.nxt_raddr];
        rsp_reg.prv_rd <= prv_mem[cmd.prv_raddr];
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/lru_block_translation_cache_unit.sv =====
// LRU block translation cache, top level: sequencer, list head and tail,
// register port and result register. Uses lbtc_pkg, lbtc_map, lbtc_lru.
//
// Usage:
//   Input items enter on s_tvalid/s_tready: s_tuser is the access kind
//   (0 read with fill on miss, 1 touch only), s_tdata[27:0] the address.
//   Each item yields one result item on m_tvalid/m_tready carrying hit,
//   mapped address, fetch request and eviction report.
//   An item holds the sequencer from accept to next accept: a touch miss or
//   a hit on the most recent slot steps from lookup to done, a read miss
//   adds an eviction step when a block is evicted, a hit needing a list
//   move adds one or two link steps; m_tvalid rises as the sequencer is free
//   again. Each map and link memory has a single write port, stepped one
//   read-modify-write at a time. s_tready is high only while idle.
//   The result register frees the input side: a new item is accepted while
//   a result waits; if the receiver stalls, the next finished item waits in
//   the sequencer until the result register empties.
//   After reset, and after every write of active_slots at address 0, a
//   clearing pass over every block entry empties the maps and rebuilds the
//   list; no item is accepted meanwhile. prdata returns the saturated count.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_translation_cache_unit
    import lbtc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // address[27:0], zero pad
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // hit, mapped_address[25:0], fetch_needed,
                                        // fetch_block[11:0], fetch_slot[9:0],
                                        // evicted_valid, evicted_block[11:0], zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t            state_reg, state_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic              kind_reg, kind_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [BLOCK_BITS-1:0] ofs_reg, ofs_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic              fetch_reg, fetch_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [BLK_W-1:0]  ev_blk_reg, ev_blk_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;

    map_cmd_t map_cmd;
    map_rsp_t map_rsp;
    lru_cmd_t lru_cmd;
    lru_rsp_t lru_rsp;

    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_raw;
    logic [CNT_W-1:0]  cfg_sat;
    logic [CLR_W:0]    clr_p1;
    logic [MAPPED_W-1:0] mapped;
    logic              in_acc;

    lbtc_map u_map
    (
        .clk (clk),
        .cmd (map_cmd),
        .rsp (map_rsp)
    );

    lbtc_lru u_lru
    (
        .clk (clk),
        .cmd (lru_cmd),
        .rsp (lru_rsp)
    );

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_SLOTS);
    assign cfg_raw  = pwdata[CNT_W-1:0];
    assign prdata   = (paddr[2] == REG_ACTIVE_SLOTS) ? {{(32-CNT_W){1'b0}}, active_reg} : 32'd0;

    always_comb
    begin
        priority if (cfg_raw < MIN_ACTIVE)
        begin
            cfg_sat = MIN_ACTIVE;
        end
        else if (cfg_raw > MAX_ACTIVE)
        begin
            cfg_sat = MAX_ACTIVE;
        end
        else
        begin
            cfg_sat = cfg_raw;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign clr_p1   = {1'b0, clr_reg} + {{CLR_W{1'b0}}, 1'b1};
    assign mapped   = (kind_reg == KIND_READ)
                    ? MAPPED_W'({slot_reg, ofs_reg}) : {MAPPED_W{1'b0}};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        active_next    = active_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        ofs_next       = ofs_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        fetch_next     = fetch_reg;
        ev_valid_next  = ev_valid_reg;
        ev_blk_next    = ev_blk_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        map_cmd           = '0;
        map_cmd.b2s_raddr = s_tdata[BLOCK_BITS +: BLK_W];
        map_cmd.own_raddr = head_reg;
        lru_cmd           = '0;
        lru_cmd.nxt_raddr = head_reg;
        lru_cmd.prv_raddr = head_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_cmd.b2s_we    = 1'b1;
                map_cmd.b2s_waddr = clr_reg[BLK_W-1:0];
                if (clr_reg < CLR_LIST_END)
                begin
                    map_cmd.own_we    = 1'b1;
                    map_cmd.own_waddr = clr_reg[SLOT_W-1:0];
                    lru_cmd.nxt_we    = 1'b1;
                    lru_cmd.nxt_waddr = clr_reg[SLOT_W-1:0];
                    lru_cmd.nxt_wdata = (clr_p1 < {{(CLR_W+1-CNT_W){1'b0}}, active_reg})
                                      ? clr_p1[SLOT_W-1:0] : {SLOT_W{1'b0}};
                    lru_cmd.prv_we    = 1'b1;
                    lru_cmd.prv_waddr = clr_reg[SLOT_W-1:0];
                    lru_cmd.prv_wdata = (clr_reg == {CLR_W{1'b0}})
                                      ? {SLOT_W{1'b0}}
                                      : clr_reg[SLOT_W-1:0] - {{(SLOT_W-1){1'b0}}, 1'b1};
                end
                clr_next = clr_p1[CLR_W-1:0];
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next  = s_tuser;
                    blk_next   = s_tdata[BLOCK_BITS +: BLK_W];
                    ofs_next   = s_tdata[BLOCK_BITS-1:0];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                hit_next      = map_rsp.b2s_rd.valid;
                fetch_next    = 1'b0;
                ev_valid_next = 1'b0;
                ev_blk_next   = {BLK_W{1'b0}};
                priority if (map_rsp.b2s_rd.valid)
                begin
                    slot_next         = map_rsp.b2s_rd.slot;
                    lru_cmd.nxt_raddr = map_rsp.b2s_rd.slot;
                    lru_cmd.prv_raddr = map_rsp.b2s_rd.slot;
                    state_next = (map_rsp.b2s_rd.slot == tail_reg) ? ST_DONE : ST_LINK;
                end
                else if (kind_reg == KIND_TOUCH)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next                = head_reg;
                    map_cmd.own_we           = 1'b1;
                    map_cmd.own_waddr        = head_reg;
                    map_cmd.own_wdata.full   = 1'b1;
                    map_cmd.own_wdata.blk    = blk_reg;
                    map_cmd.b2s_we           = 1'b1;
                    map_cmd.b2s_waddr        = blk_reg;
                    map_cmd.b2s_wdata.valid  = 1'b1;
                    map_cmd.b2s_wdata.slot   = head_reg;
                    fetch_next               = 1'b1;
                    ev_valid_next            = map_rsp.own_rd.full;
                    ev_blk_next              = map_rsp.own_rd.full
                                             ? map_rsp.own_rd.blk : {BLK_W{1'b0}};
                    head_next                = lru_rsp.nxt_rd;
                    lru_cmd.prv_we           = 1'b1;
                    lru_cmd.prv_waddr        = head_reg;
                    lru_cmd.prv_wdata        = tail_reg;
                    lru_cmd.nxt_we           = 1'b1;
                    lru_cmd.nxt_waddr        = tail_reg;
                    lru_cmd.nxt_wdata        = head_reg;
                    tail_next                = head_reg;
                    state_next = map_rsp.own_rd.full ? ST_EVICT : ST_DONE;
                end
            end
            ST_EVICT:
            begin
                map_cmd.b2s_we    = 1'b1;
                map_cmd.b2s_waddr = ev_blk_reg;
                state_next        = ST_DONE;
            end
            ST_LINK:
            begin
                if (slot_reg == head_reg)
                begin
                    head_next         = lru_rsp.nxt_rd;
                    lru_cmd.prv_we    = 1'b1;
                    lru_cmd.prv_waddr = slot_reg;
                    lru_cmd.prv_wdata = tail_reg;
                    lru_cmd.nxt_we    = 1'b1;
                    lru_cmd.nxt_waddr = tail_reg;
                    lru_cmd.nxt_wdata = slot_reg;
                    tail_next         = slot_reg;
                    state_next        = ST_DONE;
                end
                else
                begin
                    lru_cmd.nxt_we    = 1'b1;
                    lru_cmd.nxt_waddr = lru_rsp.prv_rd;
                    lru_cmd.nxt_wdata = lru_rsp.nxt_rd;
                    lru_cmd.prv_we    = 1'b1;
                    lru_cmd.prv_waddr = lru_rsp.nxt_rd;
                    lru_cmd.prv_wdata = lru_rsp.prv_rd;
                    state_next        = ST_LINK2;
                end
            end
            ST_LINK2:
            begin
                lru_cmd.prv_we    = 1'b1;
                lru_cmd.prv_waddr = slot_reg;
                lru_cmd.prv_wdata = tail_reg;
                lru_cmd.nxt_we    = 1'b1;
                lru_cmd.nxt_waddr = tail_reg;
                lru_cmd.nxt_wdata = slot_reg;
                tail_next         = slot_reg;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0,
                                      ev_blk_reg,
                                      ev_valid_reg,
                                      fetch_reg ? slot_reg : {SLOT_W{1'b0}},
                                      fetch_reg ? blk_reg : {BLK_W{1'b0}},
                                      fetch_reg,
                                      mapped,
                                      hit_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = {CLR_W{1'b0}};
            end
        endcase

        // restart the clearing pass with the new slot count
        if (cfg_we)
        begin
            active_next = cfg_sat;
            head_next   = {SLOT_W{1'b0}};
            tail_next   = SLOT_W'(cfg_sat - {{(CNT_W-1){1'b0}}, 1'b1});
            clr_next    = {CLR_W{1'b0}};
            state_next  = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= {CLR_W{1'b0}};
            active_reg    <= MAX_ACTIVE;
            head_reg      <= {SLOT_W{1'b0}};
            tail_reg      <= SLOT_W'(MAX_SLOTS - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        blk_reg      <= blk_next;
        ofs_reg      <= ofs_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        fetch_reg    <= fetch_next;
        ev_valid_reg <= ev_valid_next;
        ev_blk_reg   <= ev_blk_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $past(s_tvalid && s_tready))
        else $error("lookup step without an accepted item");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SLOTS)) |=> !s_tready)
        else $error("input ready right after a slot count write");

    a_head_tail_apart: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg != tail_reg)
        else $error("list head and tail collapsed");

    a_evict_has_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[50]) |-> (m_tdata[27] && !m_tdata[0]))
        else $error("eviction reported without a fetch on a miss");
`endif

endmodule

`default_nettype wire
